// File: design/assert_macros.svh
// assertion macros used by the table core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every rising edge outside reset
`define BLT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check a property on every rising edge, reset included
`define BLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLT_ASSERT(lbl, clk, rstn, prop, msg)
`define BLT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: design/blt_pkg.sv
// types, constants and helpers of the bucketed linked-list table
`default_nettype none

package blt_pkg;

    localparam int LINK_W   = 7;
    localparam int KEY_W    = 8;
    localparam int TAG_W    = 16;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int BOUND_W  = 8;
    localparam int DATA_W   = KEY_W + TAG_W + 1;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [LINK_W-1:0] NIL_LINK = 7'd127;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_CHANGE = 2'd1,
        OP_LIST   = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_BAD_RANGE   = 3'd2,
        ST_EMPTY       = 3'd3,
        ST_NOT_STORED  = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUND_FIRST  = 2'd0,
        CFG_BOUND_SECOND = 2'd1,
        CFG_BOUND_THIRD  = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_DATA,
        S_SCAN_HEAD,
        S_SCAN,
        S_FIX_HEAD,
        S_FIX_LINK,
        S_APP_START,
        S_APPEND,
        S_EMIT,
        S_LIST
    } state_t;

    // bucket of a key, bounds compared in cascade order
    function automatic logic [1:0] bucket_of(
        input logic [KEY_W-1:0]   k,
        input logic [BOUND_W-1:0] b0,
        input logic [BOUND_W-1:0] b1,
        input logic [BOUND_W-1:0] b2
    );
        logic [1:0] b;
        if (k <= b0)      b = 2'd0;
        else if (k <= b1) b = 2'd1;
        else if (k <= b2) b = 2'd2;
        else              b = 2'd3;
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/blt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module blt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/bucketed_linked_list_table_core.sv
// top level of the bucketed linked-list table: control, bucket heads and memories
`default_nettype none
`include "assert_macros.svh"

// Entries live in two memories with registered reads: a data memory (key, tag,
// active flag) and a link memory (next slot of each entry); four bucket heads
// and the fill count sit in flip-flops. One item is handled at a time, and
// every list step costs one link-memory read, so timing follows the list
// lengths: add walks to the tail of the target bucket, list gives one beat per
// entry, and change walks to the entry across the buckets, then to the tail of
// the new bucket. A finished beat waits in the output register while the next
// item is taken. No clearing pass follows reset.
module bucketed_linked_list_table_core #(
    parameter int ENTRIES = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [blt_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [blt_pkg::BOUND_W-1:0]   cfg_wdata,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // op[1:0], key[9:2], tag[25:10], slot[31:26], range_low[39:32], range_high[47:40]
    input  wire logic [blt_pkg::IN_W-1:0]      s_tdata,
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[2:0], entry_slot[8:3], entry_key[16:9], entry_tag[32:17],
    // entry_active[33], zero pad[39:34]
    output logic [blt_pkg::OUT_W-1:0]          m_tdata,
    output logic                               m_tlast
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int LW    = blt_pkg::LINK_W;
    localparam int KW    = blt_pkg::KEY_W;
    localparam int TW    = blt_pkg::TAG_W;
    localparam int DW    = blt_pkg::DATA_W;
    localparam int PAD_W = blt_pkg::OUT_W - blt_pkg::STATUS_W - blt_pkg::SLOT_W - DW;

    // input field unpack
    blt_pkg::op_t                 in_op;
    logic [KW-1:0]                in_key;
    logic [TW-1:0]                in_tag;
    logic [blt_pkg::SLOT_W-1:0]   in_slot;
    logic [KW-1:0]                in_lo;
    logic [KW-1:0]                in_hi;

    assign in_op   = blt_pkg::op_t'(s_tdata[1:0]);
    assign in_key  = s_tdata[9:2];
    assign in_tag  = s_tdata[25:10];
    assign in_slot = s_tdata[31:26];
    assign in_lo   = s_tdata[39:32];
    assign in_hi   = s_tdata[47:40];

    // registers
    blt_pkg::state_t          state_reg, state_next;
    blt_pkg::op_t             op_reg, op_next;
    blt_pkg::status_t         status_reg, status_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic [IDX_W-1:0]         cur_reg, cur_next;
    logic [IDX_W-1:0]         s_reg, s_next;
    logic [1:0]               b_reg, b_next;
    logic [KW-1:0]            key_reg, key_next;
    logic [TW-1:0]            tag_reg, tag_next;
    logic                     act_reg, act_next;
    logic [LW-1:0]            head_reg [4];
    logic [LW-1:0]            head_next [4];
    logic                     out_valid_reg, out_valid_next;
    logic [blt_pkg::OUT_W-1:0] out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;
    logic [blt_pkg::BOUND_W-1:0] bound0_reg, bound1_reg, bound2_reg;

    // memory ports
    logic            d_we;
    logic [IDX_W-1:0] d_waddr, d_raddr;
    logic [DW-1:0]   d_wdata, d_rdata;
    logic            l_we;
    logic [IDX_W-1:0] l_waddr, l_raddr;
    logic [LW-1:0]   l_wdata, l_rdata;
    logic            rd_slot_data;
    logic            rd_slot_link;

    // misc combinational
    logic            accept;
    logic            out_free;
    logic [1:0]      head_sel;
    logic [LW-1:0]   head_val;
    logic [1:0]      new_bucket;
    logic [1:0]      list_bucket;
    logic            list_ok;
    logic            head_ok;
    logic            link_ok;
    logic            full;
    logic            slot_stored;

    assign s_tready = (state_reg == blt_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign full        = (fill_reg == CNT_W'(ENTRIES));
    assign slot_stored = ({1'b0, in_slot} < LW'(fill_reg));
    assign new_bucket  = blt_pkg::bucket_of(key_reg, bound0_reg, bound1_reg, bound2_reg);

    // bucket picked by a list range
    always_comb
    begin
        list_ok     = 1'b1;
        list_bucket = 2'd0;
        if (in_hi <= bound0_reg)
        begin
            list_bucket = 2'd0;
        end
        else if (in_lo > bound0_reg && in_hi <= bound1_reg)
        begin
            list_bucket = 2'd1;
        end
        else if (in_lo > bound1_reg && in_hi <= bound2_reg)
        begin
            list_bucket = 2'd2;
        end
        else if (in_lo > bound2_reg && in_hi >= in_lo)
        begin
            list_bucket = 2'd3;
        end
        else
        begin
            list_ok = 1'b0;
        end
    end

    // single read of the head registers
    always_comb
    begin
        case (state_reg)
            blt_pkg::S_IDLE:      head_sel = list_bucket;
            blt_pkg::S_SCAN_HEAD: head_sel = b_reg;
            default:              head_sel = new_bucket;
        endcase
    end

    assign head_val = head_reg[head_sel];
    assign head_ok  = (head_val < LW'(ENTRIES));
    assign link_ok  = (l_rdata < LW'(ENTRIES));

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        fill_next      = fill_reg;
        cur_next       = cur_reg;
        s_next         = s_reg;
        b_next         = b_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        act_next       = act_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        d_we           = 1'b0;
        d_waddr        = s_reg;
        d_wdata        = {act_reg, tag_reg, key_reg};
        l_we           = 1'b0;
        l_waddr        = cur_reg;
        l_wdata        = blt_pkg::NIL_LINK;
        rd_slot_data   = 1'b0;
        rd_slot_link   = 1'b0;

        unique case (state_reg)
            blt_pkg::S_IDLE:
            begin
                rd_slot_data = (in_op != blt_pkg::OP_LIST);
                if (accept)
                begin
                    op_next  = in_op;
                    key_next = in_key;
                    unique case (in_op) inside
                        blt_pkg::OP_ADD:
                        begin
                            if (full)
                            begin
                                status_next = blt_pkg::ST_FULL;
                                state_next  = blt_pkg::S_EMIT;
                            end
                            else
                            begin
                                status_next = blt_pkg::ST_OK;
                                s_next      = fill_reg[IDX_W-1:0];
                                tag_next    = in_tag;
                                act_next    = 1'b1;
                                d_we        = 1'b1;
                                d_waddr     = fill_reg[IDX_W-1:0];
                                d_wdata     = {1'b1, in_tag, in_key};
                                fill_next   = fill_reg + CNT_W'(1);
                                state_next  = blt_pkg::S_APP_START;
                            end
                        end
                        blt_pkg::OP_CHANGE,
                        blt_pkg::OP_REMOVE:
                        begin
                            if (slot_stored)
                            begin
                                status_next = blt_pkg::ST_OK;
                                s_next      = in_slot[IDX_W-1:0];
                                state_next  = blt_pkg::S_RD_DATA;
                            end
                            else
                            begin
                                status_next = blt_pkg::ST_NOT_STORED;
                                state_next  = blt_pkg::S_EMIT;
                            end
                        end
                        blt_pkg::OP_LIST:
                        begin
                            if (!list_ok)
                            begin
                                status_next = blt_pkg::ST_BAD_RANGE;
                                state_next  = blt_pkg::S_EMIT;
                            end
                            else if (!head_ok)
                            begin
                                status_next = blt_pkg::ST_EMPTY;
                                state_next  = blt_pkg::S_EMIT;
                            end
                            else
                            begin
                                status_next = blt_pkg::ST_OK;
                                cur_next    = head_val[IDX_W-1:0];
                                state_next  = blt_pkg::S_LIST;
                            end
                        end
                    endcase
                end
            end

            // entry contents arrive; rewrite key or clear active
            blt_pkg::S_RD_DATA:
            begin
                tag_next = d_rdata[DW-2 -: TW];
                if (op_reg == blt_pkg::OP_REMOVE)
                begin
                    key_next   = d_rdata[KW-1:0];
                    act_next   = 1'b0;
                    state_next = blt_pkg::S_EMIT;
                end
                else
                begin
                    act_next   = d_rdata[DW-1];
                    b_next     = 2'd0;
                    state_next = blt_pkg::S_SCAN_HEAD;
                end
                d_we    = 1'b1;
                d_wdata = {act_next, tag_next, key_next};
            end

            // look at the head of bucket b for the moved slot
            blt_pkg::S_SCAN_HEAD:
            begin
                if (!head_ok)
                begin
                    b_next     = b_reg + 2'd1;
                    state_next = (b_reg == 2'd3) ? blt_pkg::S_APP_START
                                                 : blt_pkg::S_SCAN_HEAD;
                end
                else if (head_val == LW'(s_reg))
                begin
                    rd_slot_link = 1'b1;
                    state_next   = blt_pkg::S_FIX_HEAD;
                end
                else
                begin
                    cur_next   = head_val[IDX_W-1:0];
                    state_next = blt_pkg::S_SCAN;
                end
            end

            // follow links of bucket b; cur holds the node whose link arrived
            blt_pkg::S_SCAN:
            begin
                if (!link_ok)
                begin
                    b_next     = b_reg + 2'd1;
                    state_next = (b_reg == 2'd3) ? blt_pkg::S_APP_START
                                                 : blt_pkg::S_SCAN_HEAD;
                end
                else if (l_rdata == LW'(s_reg))
                begin
                    rd_slot_link = 1'b1;
                    state_next   = blt_pkg::S_FIX_LINK;
                end
                else
                begin
                    cur_next = l_rdata[IDX_W-1:0];
                end
            end

            // slot was a head: head takes its successor
            blt_pkg::S_FIX_HEAD:
            begin
                head_next[b_reg] = l_rdata;
                state_next       = blt_pkg::S_APP_START;
            end

            // slot was inside a list: predecessor takes its successor
            blt_pkg::S_FIX_LINK:
            begin
                l_we       = 1'b1;
                l_waddr    = cur_reg;
                l_wdata    = l_rdata;
                state_next = blt_pkg::S_APP_START;
            end

            // terminate the slot and start the tail search of the new bucket
            blt_pkg::S_APP_START:
            begin
                l_we    = 1'b1;
                l_waddr = s_reg;
                l_wdata = blt_pkg::NIL_LINK;
                if (!head_ok)
                begin
                    head_next[new_bucket] = LW'(s_reg);
                    state_next            = blt_pkg::S_EMIT;
                end
                else
                begin
                    cur_next   = head_val[IDX_W-1:0];
                    state_next = blt_pkg::S_APPEND;
                end
            end

            // walk to the tail and hook the slot behind it
            blt_pkg::S_APPEND:
            begin
                if (!link_ok)
                begin
                    l_we       = 1'b1;
                    l_waddr    = cur_reg;
                    l_wdata    = LW'(s_reg);
                    state_next = blt_pkg::S_EMIT;
                end
                else
                begin
                    cur_next = l_rdata[IDX_W-1:0];
                end
            end

            // single result beat
            blt_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (status_reg == blt_pkg::ST_OK)
                    begin
                        out_data_next = {PAD_W'(0), act_reg, tag_reg, key_reg,
                                         blt_pkg::SLOT_W'(s_reg), status_reg};
                    end
                    else
                    begin
                        out_data_next = {PAD_W'(0), DW'(0), blt_pkg::SLOT_W'(0),
                                         status_reg};
                    end
                    state_next = blt_pkg::S_IDLE;
                end
            end

            // one beat per list entry, data and link of cur arrive together
            blt_pkg::S_LIST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = !link_ok;
                    out_data_next  = {PAD_W'(0), d_rdata, blt_pkg::SLOT_W'(cur_reg),
                                      blt_pkg::ST_OK};
                    if (!link_ok)
                    begin
                        state_next = blt_pkg::S_IDLE;
                    end
                    else
                    begin
                        cur_next = l_rdata[IDX_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = blt_pkg::S_IDLE;
            end
        endcase
    end

    assign d_raddr = rd_slot_data ? in_slot[IDX_W-1:0] : cur_next;
    assign l_raddr = rd_slot_link ? s_reg : cur_next;

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blt_pkg::S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            head_reg      <= '{default: blt_pkg::NIL_LINK};
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    // bound registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound0_reg <= 8'd5;
            bound1_reg <= 8'd10;
            bound2_reg <= 8'd18;
        end
        else if (cfg_we)
        begin
            unique case (blt_pkg::cfg_idx_t'(cfg_addr))
                blt_pkg::CFG_BOUND_FIRST:  bound0_reg <= cfg_wdata;
                blt_pkg::CFG_BOUND_SECOND: bound1_reg <= cfg_wdata;
                blt_pkg::CFG_BOUND_THIRD:  bound2_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        status_reg   <= status_next;
        cur_reg      <= cur_next;
        s_reg        <= s_next;
        b_reg        <= b_next;
        key_reg      <= key_next;
        tag_reg      <= tag_next;
        act_reg      <= act_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // entry data memory: {active, tag, key}
    blt_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    // next-link memory
    blt_ram #(
        .WIDTH (LW),
        .DEPTH (ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    // checks
    `BLT_ASSERT_ALWAYS(a_fill_bound, clk, fill_reg <= CNT_W'(ENTRIES), "fill count beyond table size")
    `BLT_ASSERT(a_fill_only_add, clk, rst_n, !(accept && in_op == blt_pkg::OP_ADD) |=> $stable(fill_reg), "fill count moved without an add")
    `BLT_ASSERT(a_no_self_link, clk, rst_n, (l_we && state_reg == blt_pkg::S_APPEND) |-> (l_waddr != s_reg), "appended slot linked to itself")
    `BLT_ASSERT(a_list_in_table, clk, rst_n, (state_reg == blt_pkg::S_LIST) |-> (LW'(cur_reg) < LW'(fill_reg)), "list walk left the stored entries")

endmodule

`default_nettype wire
